// ===== rtl/lcdnp_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnp_pkg
// Shared types, codes and constant tables for the character display nibble
// port sequencer.
// ----------------------------------------------------------------------------
package lcdnp_pkg;

   localparam int ROWS_DEFAULT    = 4;
   localparam int COLUMNS_DEFAULT = 20;

   // command codes
   localparam logic [1:0] ACT_INIT   = 2'd0;
   localparam logic [1:0] ACT_CURSOR = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_PRINT  = 2'd3;

   // display commands
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;

   // timing, in milliseconds
   localparam logic [5:0] DLY_POWER_UP = 6'd50;
   localparam logic [5:0] DLY_PULSE    = 6'd1;
   localparam logic [5:0] DLY_CLEAR    = 6'd3;
   localparam logic [5:0] DLY_NONE     = 6'd0;

   // word counts per command, minus one
   localparam logic [4:0] LAST_INIT = 5'd28;
   localparam logic [4:0] LAST_BYTE = 5'd3;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [3:0] nib;
      logic [5:0] dly;
   } init_entry_type;

   // descriptor of the word the sequencer asks for
   typedef struct packed {
      logic       is_init;
      logic [4:0] cnt;
      logic [7:0] data;
      logic       rs;
      logic [5:0] final_dly;
      logic       bl;
   } step_type;

   typedef struct packed {
      logic [7:0] port;
      logic [5:0] dly;
   } word_type;

   // DDRAM start address of each display row
   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0: base = 8'h00;
         2'd1: base = 8'h40;
         2'd2: base = 8'h14;
         2'd3: base = 8'h54;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

   // power-up nibble list: three wake-ups, 4-bit switch, then five bytes
   function automatic init_entry_type init_nibble(input logic [3:0] idx);
      init_entry_type e;
      case (idx)
         4'd0:  e = '{4'h3, 6'd5};
         4'd1:  e = '{4'h3, 6'd1};
         4'd2:  e = '{4'h3, 6'd1};
         4'd3:  e = '{4'h2, 6'd1};
         4'd4:  e = '{4'h2, 6'd1};  // function set, 2 lines
         4'd5:  e = '{4'h8, 6'd1};
         4'd6:  e = '{4'h0, 6'd1};  // display on
         4'd7:  e = '{4'hC, 6'd0};
         4'd8:  e = '{4'h0, 6'd1};  // clear
         4'd9:  e = '{4'h1, 6'd3};
         4'd10: e = '{4'h0, 6'd1};  // entry mode
         4'd11: e = '{4'h6, 6'd0};
         4'd12: e = '{4'h8, 6'd1};  // home cursor
         4'd13: e = '{4'h0, 6'd0};
         default: e = '{4'h0, 6'd0};
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/lcdnp_if.sv =====
// ----------------------------------------------------------------------------
// lcdnp_req_if / lcdnp_rsp_if
// Valid/ready channels for commands in and expander port words out.
// ----------------------------------------------------------------------------
interface lcdnp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] cursor_column;
   logic [7:0] cursor_row;
   logic [7:0] char_code;
   logic       device_present;

   modport source (output valid, action, cursor_column, cursor_row, char_code,
                   device_present, input ready);
   modport sink   (input valid, action, cursor_column, cursor_row, char_code,
                   device_present, output ready);
endinterface

interface lcdnp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] port_byte;
   logic [5:0] delay_ms;
   logic       last;

   modport source (output valid, port_byte, delay_ms, last, input ready);
   modport sink   (input valid, port_byte, delay_ms, last, output ready);
endinterface

// ===== rtl/lcdnp_word_former.sv =====
// ----------------------------------------------------------------------------
// lcdnp_word_former
// Shared unit: turns a step descriptor into one expander port word and delay.
// ----------------------------------------------------------------------------
module lcdnp_word_former
   import lcdnp_pkg::*;
(
   input  step_type step,
   output word_type word
);

   logic [4:0]     k;
   logic [3:0]     nib_idx;
   init_entry_type entry;
   logic [3:0]     nib;
   logic [5:0]     dly_after;
   logic           en;

   always_comb begin
      // init has one leading backlight-only word before the nibble stream
      k       = step.is_init ? (step.cnt - 5'd1) : step.cnt;
      nib_idx = k[4:1];
      en      = ~k[0];
      entry   = init_nibble(nib_idx);
      if (step.is_init) begin
         nib       = entry.nib;
         dly_after = entry.dly;
      end else begin
         nib       = nib_idx[0] ? step.data[3:0] : step.data[7:4];
         dly_after = nib_idx[0] ? step.final_dly : DLY_PULSE;
      end
      if (step.is_init && step.cnt == 5'd0) begin
         word.port = {4'h0, 1'b1, 1'b0, 1'b0, 1'b0};
         word.dly  = DLY_POWER_UP;
      end else begin
         word.port = {nib, step.bl, en, 1'b0, step.rs};
         word.dly  = k[0] ? dly_after : DLY_PULSE;
      end
   end

endmodule

// ===== rtl/hd44780_nibble_port_sequencer.sv =====
// ----------------------------------------------------------------------------
// hd44780_nibble_port_sequencer
// Expands display commands into 4-bit-mode expander port words.
// ----------------------------------------------------------------------------
// Flow: the command is captured on acceptance; each word is then registered.
// Throughput: one word per cycle while the output is taken; init makes 29 words
//   and other commands 4 words, counted by the step counter driving the word
//   former; the input stays not ready until the last word is registered.
// Ignored commands produce no word and leave the block ready the next cycle.
// Reset: synchronous; clears initialized and backlight flags, state, output valid.
// ----------------------------------------------------------------------------
module hd44780_nibble_port_sequencer
   import lcdnp_pkg::*;
#(
   parameter int ROWS    = ROWS_DEFAULT,
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lcdnp_req_if.sink    req,
   lcdnp_rsp_if.source  rsp
);

   // control state
   state_type  state_ff, state_in;
   logic       initialized_ff, initialized_in;
   logic       backlight_ff, backlight_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] cnt_ff, cnt_in;

   // command held for the run
   logic       is_init_ff, is_init_in;
   logic [7:0] data_ff, data_in;
   logic       rs_ff, rs_in;
   logic [5:0] final_dly_ff, final_dly_in;
   logic [4:0] last_ff, last_in;

   // output word register
   logic [7:0] port_ff, port_in;
   logic [5:0] dly_ff, dly_in;
   logic       rsp_last_ff, rsp_last_in;

   step_type   step;
   word_type   word;
   logic       in_range;
   logic [7:0] cursor_addr;

   assign step = '{is_init: is_init_ff, cnt: cnt_ff, data: data_ff, rs: rs_ff,
                   final_dly: final_dly_ff, bl: backlight_ff};

   lcdnp_word_former u_former (
      .step (step),
      .word (word)
   );

   // cursor position check and DDRAM address
   assign in_range    = (int'(req.cursor_row) < ROWS) && (int'(req.cursor_column) < COLUMNS);
   assign cursor_addr = CMD_SET_DDRAM | (req.cursor_column + row_base(req.cursor_row[1:0]));

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.port_byte = port_ff;
   assign rsp.delay_ms  = dly_ff;
   assign rsp.last      = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      initialized_in = initialized_ff;
      backlight_in   = backlight_ff;
      rsp_valid_in   = rsp_valid_ff;
      cnt_in         = cnt_ff;
      is_init_in     = is_init_ff;
      data_in        = data_ff;
      rs_in          = rs_ff;
      final_dly_in   = final_dly_ff;
      last_in        = last_ff;
      port_in        = port_ff;
      dly_in         = dly_ff;
      rsp_last_in    = rsp_last_ff;

      // drop the word once the sink takes it
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cnt_in       = 5'd0;
               is_init_in   = 1'b0;
               rs_in        = 1'b0;
               final_dly_in = DLY_NONE;
               last_in      = LAST_BYTE;
               case (req.action)
                  ACT_INIT: begin
                     // start power-up only on a present, fresh device
                     if (!initialized_ff && req.device_present) begin
                        state_in       = ST_RUN;
                        is_init_in     = 1'b1;
                        last_in        = LAST_INIT;
                        initialized_in = 1'b1;
                        backlight_in   = 1'b1;
                     end
                  end
                  ACT_CURSOR: begin
                     data_in = cursor_addr;
                     if (initialized_ff && in_range) begin
                        state_in = ST_RUN;
                     end
                  end
                  ACT_CLEAR: begin
                     data_in      = CMD_CLEAR;
                     final_dly_in = DLY_CLEAR;
                     if (initialized_ff) begin
                        state_in = ST_RUN;
                     end
                  end
                  ACT_PRINT: begin
                     data_in = req.char_code;
                     rs_in   = 1'b1;
                     if (initialized_ff) begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            // advance when the output register is free or being emptied
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               port_in      = word.port;
               dly_in       = word.dly;
               rsp_last_in  = (cnt_ff == last_ff);
               if (cnt_ff == last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         initialized_ff <= 1'b0;
         backlight_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= 5'd0;
      end else begin
         state_ff       <= state_in;
         initialized_ff <= initialized_in;
         backlight_ff   <= backlight_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      is_init_ff   <= is_init_in;
      data_ff      <= data_in;
      rs_ff        <= rs_in;
      final_dly_ff <= final_dly_in;
      last_ff      <= last_in;
      port_ff      <= port_in;
      dly_ff       <= dly_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // a run only exists once the display has been brought up
   a_run_needs_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (initialized_ff && backlight_ff))
      else $error("sequencer running before init");

   // the step counter never passes the last word of the command
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff <= last_ff))
      else $error("step counter overran command");

   // emitting the last word always returns the sequencer to idle
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && (!rsp_valid_ff || rsp.ready) && (cnt_ff == last_ff))
      |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("last word did not end the run");

endmodule
